// File: rtl/b64d_pkg.sv
package b64d_pkg;

  // ASCII code of the padding character
  localparam logic [7:0] EQ_CHAR = 8'h3D;

  // Reset value of the byte limit
  localparam logic [7:0] MAX_BYTES_RESET = 8'hFF;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One input item
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } b64d_in_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic [7:0] out_count;
  } b64d_out_t;

  // Work for the back end: the results one input item causes
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            last;
    logic [7:0]      count;
  } b64d_job_t;

  // Map one character to its 6-bit value; padding and unknown codes give zero
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] v;
    v = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 6'd62;
    end else if (c == 8'h2F) begin
      v = 6'd63;
    end
    return v;
  endfunction

endpackage

// File: rtl/b64d_front.sv
module b64d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_ready,
  input  b64d_pkg::b64d_in_t  text,
  input  logic [7:0]          max_bytes,
  input  logic                q_ready,
  output logic                q_push,
  output b64d_pkg::b64d_job_t q_job
);

  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_pos, group_pos_next;
  logic [1:0]  pad_marks, pad_marks_next;
  logic [7:0]  byte_count, byte_count_next;

  logic        accept;
  logic        is_pad;
  logic [1:0]  pad0, pad1, padf;
  logic [1:0]  pos1;
  logic [23:0] bits1, bitsf;
  logic        complete;
  logic [1:0]  nwant, ntake;
  logic [7:0]  avail;

  assign text_ready = q_ready;
  assign accept     = text_valid && q_ready;

  // Absorb the character, pad out a short final group, pick the bytes to emit
  always_comb begin
    is_pad = (text.in_char == b64d_pkg::EQ_CHAR);
    pad0   = (group_pos == 2'd0) ? 2'b00 : pad_marks;
    bits1  = {group_bits[17:0], b64d_pkg::sextet_of(text.in_char)};
    pad1   = pad0;
    if (is_pad && group_pos == 2'd2) begin
      pad1[0] = 1'b1;
    end
    if (is_pad && group_pos == 2'd3) begin
      pad1[1] = 1'b1;
    end
    pos1  = group_pos + 2'd1;
    bitsf = bits1;
    padf  = pad1;
    if (text.in_last && pos1 != 2'd0) begin
      case (pos1)
        2'd1: begin
          bitsf = bits1 << 18;
          padf  = 2'b11;
        end
        2'd2: begin
          bitsf = bits1 << 12;
          padf  = 2'b11;
        end
        default: begin
          bitsf   = bits1 << 6;
          padf[1] = 1'b1;
        end
      endcase
    end
    complete = (pos1 == 2'd0) || text.in_last;
    nwant    = 2'd1 + {1'b0, ~padf[0]} + {1'b0, ~padf[1]};
    avail    = (byte_count >= max_bytes) ? 8'd0 : (max_bytes - byte_count);
    if (!complete) begin
      ntake = 2'd0;
    end else if (avail < {6'd0, nwant}) begin
      ntake = avail[1:0];
    end else begin
      ntake = nwant;
    end

    // Pack the kept bytes in order, skipping the second when the third was padding
    q_job.bytes[0] = bitsf[23:16];
    q_job.bytes[1] = padf[0] ? bitsf[7:0] : bitsf[15:8];
    q_job.bytes[2] = bitsf[7:0];
    q_job.nbytes   = ntake;
    q_job.last     = text.in_last;
    q_job.count    = byte_count + {6'd0, ntake};
    q_push         = accept && (ntake != 2'd0 || text.in_last);

    // Clear everything at the end of a text
    if (text.in_last) begin
      group_bits_next = '0;
      group_pos_next  = '0;
      pad_marks_next  = '0;
      byte_count_next = '0;
    end else begin
      group_bits_next = bits1;
      group_pos_next  = pos1;
      pad_marks_next  = pad1;
      byte_count_next = q_job.count;
    end
  end

  // Advance group state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits <= '0;
      group_pos  <= '0;
      pad_marks  <= '0;
      byte_count <= '0;
    end else if (accept) begin
      group_bits <= group_bits_next;
      group_pos  <= group_pos_next;
      pad_marks  <= pad_marks_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

// File: rtl/b64d_queue.sv
module b64d_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64d_pkg::b64d_job_t push_job,
  output logic                not_full,
  input  logic                pop,
  output logic                not_empty,
  output b64d_pkg::b64d_job_t head
);

  b64d_pkg::b64d_job_t               entries [b64d_pkg::QDEPTH];
  logic [b64d_pkg::QPTR_W-1:0]       wr_ptr, rd_ptr;
  logic [b64d_pkg::QCNT_W-1:0]       fill;

  assign not_full  = (fill != b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/b64d_back.sv
module b64d_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  b64d_pkg::b64d_job_t q_head,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_ready,
  output b64d_pkg::b64d_out_t result
);

  logic [1:0] idx;
  logic [1:0] nres;
  logic       final_res;
  logic       take;

  // Walk through the results of the head job, one item per cycle while result_ready is high
  always_comb begin
    nres                = (q_head.nbytes == 2'd0) ? 2'd1 : q_head.nbytes;
    final_res           = (idx == nres - 2'd1);
    result_valid        = q_valid;
    result.byte_valid   = (q_head.nbytes != 2'd0);
    result.out_byte     = result.byte_valid ? q_head.bytes[idx] : 8'd0;
    result.out_last     = q_head.last && final_res;
    result.out_count    = result.out_last ? q_head.count : 8'd0;
    take                = q_valid && result_ready;
    q_pop               = take && final_res;
  end

  // Step the result index; drop back to the first on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= final_res ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// File: rtl/base64_decoder_core.sv
// Base64 decoder, standard alphabet: one ASCII character per input item, zero to
// three decoded bytes out per character, one result item per cycle. '=' and
// unknown codes decode as zero; a text ending in a short group is finished as if
// padded with '='. The final character of a text (in_last) always yields a result
// with out_last set and the text's byte total in out_count, as a bare marker with
// byte_valid low if no byte goes out. cfg_max_bytes caps the bytes of one text
// (reset 255) and may be written only while the block is idle. A character is
// taken every cycle while the four-entry job queue between the decode stage and
// the output serializer has room, and its first result can be taken in the cycle
// after it is accepted. The output port sustains one result per cycle and no
// group of characters releases more results than it has characters (three bytes
// for every four characters, at most one result for each character of a short
// final group), so any text runs at one character per cycle while the output is
// never stalled; output stalls back up into the queue and then hold the input.
module base64_decoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_max_bytes,
  input  logic                text_valid,
  output logic                text_ready,
  input  b64d_pkg::b64d_in_t  text,
  output logic                result_valid,
  input  logic                result_ready,
  output b64d_pkg::b64d_out_t result
);

  logic [7:0]          max_bytes;
  logic                q_ready, q_push, q_valid, q_pop;
  b64d_pkg::b64d_job_t q_job, q_head;

  assign cfg_ready = 1'b1;

  // Hold the byte limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= b64d_pkg::MAX_BYTES_RESET;
    end else if (cfg_valid) begin
      max_bytes <= cfg_max_bytes;
    end
  end

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text),
    .max_bytes  (max_bytes),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_job),
    .not_full  (q_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  b64d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: dv/base64_decoder_core_test.sv
`timescale 1ns / 1ps

module base64_decoder_core_test;

  localparam int SETTLE_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_CHARS = 60;
  localparam int NUM_PHASES = 5;

  typedef enum int {
    KIND_PADDED,
    KIND_UNPADDED,
    KIND_NOISE,
    KIND_BROKEN
  } text_kind_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_max_bytes = 8'd0;
  logic                text_valid = 1'b0;
  logic                text_ready;
  b64d_pkg::b64d_in_t  text_item = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  b64d_pkg::b64d_out_t result;

  base64_decoder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_max_bytes (cfg_max_bytes),
    .text_valid    (text_valid),
    .text_ready    (text_ready),
    .text          (text_item),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
  );

  always #5 clk = ~clk;

  // Decoder state as predicted
  logic [7:0]  byte_limit = b64d_pkg::MAX_BYTES_RESET;
  logic [23:0] grp_bits = '0;
  logic [1:0]  grp_pos = '0;
  logic [1:0]  pad_seen = '0;
  logic [7:0]  dec_count = '0;

  b64d_pkg::b64d_out_t burst[$];
  b64d_pkg::b64d_out_t want_decoded[$];
  b64d_pkg::b64d_in_t  text_q[$];

  // Run control and bookkeeping
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit hold_send = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int chars_loaded = 0;
  int texts_loaded = 0;
  int chars_taken = 0;
  int results_seen = 0;
  int bare_markers = 0;

  // Map a character to its 6-bit value; padding and unknown codes are zero
  function automatic logic [5:0] char_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 6'(c - "A");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 6'(c - "0" + 8'd52);
    if (c == "+") return 6'd62;
    if (c == "/") return 6'd63;
    return 6'd0;
  endfunction

  // Map a 6-bit value to its alphabet character, for building texts
  function automatic logic [7:0] value_char(input logic [5:0] v);
    if (v < 6'd26) return 8'("A" + v);
    if (v < 6'd52) return 8'("a" + v - 6'd26);
    if (v < 6'd62) return 8'("0" + v - 6'd52);
    if (v == 6'd62) return "+";
    return "/";
  endfunction

  // Emit one decoded byte unless the limit is reached
  function automatic void emit_byte(input logic [7:0] b);
    b64d_pkg::b64d_out_t r;
    if (dec_count >= byte_limit || burst.size() >= 3) return;
    r = '0;
    r.out_byte = b;
    r.byte_valid = 1'b1;
    burst.push_back(r);
    dec_count = dec_count + 8'd1;
  endfunction

  // Shift one character into the group and release bytes on a full group
  function automatic void absorb_char(input logic [7:0] c);
    if (grp_pos == 2'd0) pad_seen = 2'b00;
    grp_bits = {grp_bits[17:0], char_value(c)};
    if (c == b64d_pkg::EQ_CHAR && grp_pos == 2'd2) pad_seen[0] = 1'b1;
    if (c == b64d_pkg::EQ_CHAR && grp_pos == 2'd3) pad_seen[1] = 1'b1;
    grp_pos = grp_pos + 2'd1;
    if (grp_pos == 2'd0) begin
      emit_byte(grp_bits[23:16]);
      if (!pad_seen[0]) emit_byte(grp_bits[15:8]);
      if (!pad_seen[1]) emit_byte(grp_bits[7:0]);
    end
  endfunction

  // Work out the results one accepted character causes
  function automatic void decode_char(input b64d_pkg::b64d_in_t it);
    int k;
    burst.delete();
    absorb_char(it.in_char);
    if (it.in_last) begin
      // finish a short group as if padded
      while (grp_pos != 2'd0) absorb_char(b64d_pkg::EQ_CHAR);
      if (burst.size() == 0) burst.push_back('0);
      k = burst.size() - 1;
      burst[k].out_last = 1'b1;
      burst[k].out_count = dec_count;
      grp_bits = '0;
      grp_pos = '0;
      pad_seen = '0;
      dec_count = '0;
    end
    for (k = 0; k < burst.size(); k++) want_decoded.push_back(burst[k]);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  // Compare one result item against the oldest prediction
  task automatic check_result(input b64d_pkg::b64d_out_t got);
    b64d_pkg::b64d_out_t want;
    results_seen++;
    if (want_decoded.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte=%02h valid=%0b last=%0b count=%0d",
                                got.out_byte, got.byte_valid, got.out_last, got.out_count));
      return;
    end
    want = want_decoded.pop_front();
    if (want.out_last && !want.byte_valid) bare_markers++;
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
    if (got.byte_valid !== want.byte_valid)
      report_mismatch($sformatf("byte_valid %0b, want %0b", got.byte_valid, want.byte_valid));
    if (got.out_last !== want.out_last)
      report_mismatch($sformatf("out_last %0b, want %0b", got.out_last, want.out_last));
    if (got.out_count !== want.out_count)
      report_mismatch($sformatf("out_count %0d, want %0d", got.out_count, want.out_count));
  endtask

  // Drive characters from the queue, with random gaps between items
  always @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (text_valid && text_ready) begin
        decode_char(text_item);
        chars_taken++;
        send_gap = send_idle ? $urandom_range(0, 19) : 0;
      end
      if (!text_valid || text_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          text_valid <= 1'b0;
        end else if (!hold_send && text_q.size() > 0) begin
          text_item <= text_q.pop_front();
          text_valid <= 1'b1;
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  // Take result items, stalling at random after each one
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (result_valid && result_ready) begin
        check_result(result);
        recv_gap = recv_idle ? $urandom_range(0, 19) : 0;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      result_ready <= (recv_gap == 0);
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((text_valid && text_ready) || (result_valid && result_ready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_char(input logic [7:0] c, input bit last);
    b64d_pkg::b64d_in_t it;
    it.in_char = c;
    it.in_last = last;
    text_q.push_back(it);
    chars_loaded++;
  endtask

  task automatic push_chars(input string s, input bit last_at_end);
    int j;
    for (j = 0; j < s.len(); j++) push_char(s[j], last_at_end && (j == s.len() - 1));
  endtask

  function automatic text_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) return KIND_PADDED;
    if (r <= 7) return KIND_UNPADDED;
    if (r == 8) return KIND_NOISE;
    return KIND_BROKEN;
  endfunction

  // Build one text: encoded random bytes, or noise, or a damaged encoding
  task automatic push_text(input text_kind_t kind);
    logic [7:0]  chars[$];
    logic [23:0] grp;
    int          nbytes;
    int          take;
    int          j;
    int          spot;
    if (kind == KIND_NOISE) begin
      repeat ($urandom_range(1, 10))
        chars.push_back(($urandom_range(0, 3) == 0) ? b64d_pkg::EQ_CHAR :
                        8'($urandom_range(0, 255)));
    end else begin
      nbytes = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (j = 0; j < nbytes; j += 3) begin
        take = (nbytes - j < 3) ? nbytes - j : 3;
        grp = 24'($urandom());
        if (take < 3) grp[7:0] = '0;
        if (take < 2) grp[15:8] = '0;
        chars.push_back(value_char(grp[23:18]));
        chars.push_back(value_char(grp[17:12]));
        chars.push_back((take > 1) ? value_char(grp[11:6]) : b64d_pkg::EQ_CHAR);
        chars.push_back((take > 2) ? value_char(grp[5:0]) : b64d_pkg::EQ_CHAR);
      end
      if (kind == KIND_UNPADDED) begin
        while (chars[chars.size() - 1] == b64d_pkg::EQ_CHAR) chars.pop_back();
      end
      if (kind == KIND_BROKEN) begin
        spot = $urandom_range(0, chars.size() - 1);
        chars[spot] = $urandom_range(0, 1) ? b64d_pkg::EQ_CHAR : 8'($urandom_range(0, 255));
      end
    end
    for (j = 0; j < chars.size(); j++) push_char(chars[j], j == chars.size() - 1);
    texts_loaded++;
  endtask

  // Wait for all items sent and all results back, then let the block settle
  task automatic wait_idle();
    while (text_q.size() > 0 || text_valid || want_decoded.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] lim);
    @(posedge clk);
    cfg_max_bytes <= lim;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    byte_limit = lim;
  endtask

  initial begin
    logic [7:0] limits[NUM_PHASES];
    int         ph;
    int         start;
    limits = '{8'd0, 8'd1, 8'd5, 8'd255, 8'd0};
    limits[4] = 8'($urandom_range(2, 254));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed texts under the reset limit
    push_chars("AZaz09+/", 1'b0);
    push_chars("TQ==", 1'b1);
    push_chars("TWE=", 1'b1);
    push_chars("TW", 1'b1);
    // padding in the first two positions and unknown codes
    push_char(b64d_pkg::EQ_CHAR, 1'b0);
    push_char(b64d_pkg::EQ_CHAR, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(8'h00, 1'b1);
    // single-character text
    push_chars("Z", 1'b1);
    texts_loaded += 5;
    wait_idle();

    // Random texts, one byte limit and idle pattern per phase
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_limit(limits[ph]);
      @(negedge clk);
      send_idle = (ph % 3 != 0);
      recv_idle = (ph != 1);
      start = chars_loaded;
      while (chars_loaded - start < PHASE_CHARS / 2) push_text(pick_kind());
      // hold the sender until the decoder has drained
      while (text_q.size() > 0) @(negedge clk);
      hold_send = 1'b1;
      while (text_valid || want_decoded.size() > 0) @(negedge clk);
      hold_send = 1'b0;
      while (chars_loaded - start < PHASE_CHARS) push_text(pick_kind());
      wait_idle();
    end

    $display("Decoded %0d texts from %0d characters into %0d results, %0d of them bare end markers",
             texts_loaded, chars_taken, results_seen, bare_markers);
    $display("Byte limits 255 (reset), 0, 1, 5, 255 and %0d, with idle and stall on and off",
             limits[4]);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
